/* rtl/srp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types and constants of the shelf rectangle packer: request kinds,
// register indexes and the fixed widths of the configuration registers.
// ----------------------------------------------------------------------------
package srp_pkg;

  // Default coordinate width; canvas sizes take one bit more
  localparam int unsigned COORD_BITS_DEFAULT = 16;

  // Request kind carried in tuser
  localparam int unsigned MODE_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PLACE   = 2'd0,
    MODE_COMMIT  = 2'd1,
    MODE_RESTART = 2'd2
  } mode_e;

  // Configuration registers
  localparam int unsigned PAD_W      = 8;
  localparam int unsigned SIZE_REG_W = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = SIZE_REG_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAD_X  = 2'd0,
    REG_PAD_Y  = 2'd1,
    REG_INIT_W = 2'd2,
    REG_INIT_H = 2'd3
  } cfg_reg_e;

  // Reset value of the initial and committed canvas sizes
  localparam int unsigned INIT_SIZE_RESET = 256;

endpackage
`default_nettype wire

/* rtl/srp_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srp_core
// Packer state (cursor, shelf height, committed and pending canvas) and the
// single-pass logic that works out one request's result and next state.
// ----------------------------------------------------------------------------
module srp_core
  import srp_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [COORD_BITS-1:0] rect_width_i,
  input  logic [COORD_BITS-1:0] rect_height_i,
  input  logic [PAD_W-1:0]      pad_x_i,
  input  logic [PAD_W-1:0]      pad_y_i,
  input  logic [SIZE_REG_W-1:0] init_width_i,
  input  logic [SIZE_REG_W-1:0] init_height_i,
  output logic [COORD_BITS-1:0] cell_left_o,
  output logic [COORD_BITS-1:0] cell_top_o,
  output logic [COORD_BITS-1:0] cell_right_o,
  output logic [COORD_BITS-1:0] cell_bottom_o,
  output logic [COORD_BITS:0]   canvas_width_o,
  output logic [COORD_BITS:0]   canvas_height_o,
  output logic                  overflow_o
);

  // S: sizes and cursor (up to 2^COORD_BITS), W: sums with headroom
  localparam int unsigned S  = COORD_BITS + 1;
  localparam int unsigned W  = COORD_BITS + 2;
  localparam int unsigned CW = (SIZE_REG_W > W) ? SIZE_REG_W : W;

  localparam logic [W-1:0]  CANVAS_MAX    = W'(1) << COORD_BITS;
  localparam logic [W-1:0]  COORD_MAX     = CANVAS_MAX - W'(1);
  localparam logic [CW-1:0] CANVAS_MAX_CW = CW'(CANVAS_MAX);

  // Next power of two at or above v; v lies in 1 .. 2^COORD_BITS
  function automatic logic [S-1:0] pot_up(input logic [W-1:0] v);
    logic [S-1:0] m;
    logic [S-1:0] fits;
    m = S'(v - W'(1));
    for (int i = 0; i < S; i++) begin
      fits[i] = ((m >> i) == '0);
    end
    return fits & ~(fits << 1);
  endfunction

  // Initial size on restart: zero reads as 1, too large as the canvas limit
  function automatic logic [S-1:0] clamp_size(input logic [SIZE_REG_W-1:0] v);
    logic [CW-1:0] ve;
    ve = CW'(v);
    if (ve == '0) begin
      return S'(1);
    end
    if (ve > CANVAS_MAX_CW) begin
      return S'(CANVAS_MAX);
    end
    return S'(ve);
  endfunction

  // State
  logic [S-1:0] cx_q, cy_q, sh_q, cw_q, ch_q, pw_q, ph_q;
  logic [S-1:0] cx_d, cy_d, sh_d, cw_d, ch_d, pw_d, ph_d;

  // Effective canvas before this request
  logic         pend;
  logic [S-1:0] cur_w, cur_h;

  assign pend  = (pw_q != '0);
  assign cur_w = pend ? pw_q : cw_q;
  assign cur_h = pend ? ph_q : ch_q;

  // Padded request and shelf wrap
  logic [W-1:0] req_x, req_y, wrap_y, cx1, cy1, sh1;
  logic         wrap, ovf_wrap;

  assign req_x    = W'(rect_width_i) + W'(pad_x_i);
  assign req_y    = W'(rect_height_i) + W'(pad_y_i);
  assign wrap     = (W'(cx_q) + req_x) > W'(cw_q);
  assign wrap_y   = W'(cy_q) + W'(sh_q) + W'(pad_y_i);
  assign ovf_wrap = wrap && (wrap_y > CANVAS_MAX);
  assign cx1      = wrap ? W'(pad_x_i) : W'(cx_q);
  assign cy1      = wrap ? (ovf_wrap ? CANVAS_MAX : wrap_y) : W'(cy_q);
  assign sh1      = wrap ? '0 : W'(sh_q);

  // Growth of the effective canvas
  logic [W-1:0] end_x, end_y, grow_y;
  logic         grow_w, grow_h, ovf_gw, ovf_gh;
  logic [S-1:0] new_w, new_h;

  assign end_x  = cx1 + req_x;
  assign end_y  = cy1 + req_y;
  assign grow_y = W'(cur_h) + req_y;
  assign grow_w = end_x > W'(cur_w);
  assign grow_h = end_y > W'(cur_h);
  assign ovf_gw = grow_w && (end_x > CANVAS_MAX);
  assign ovf_gh = grow_h && (grow_y > CANVAS_MAX);
  assign new_w  = !grow_w ? cur_w : (ovf_gw ? S'(CANVAS_MAX) : pot_up(end_x));
  assign new_h  = !grow_h ? cur_h : (ovf_gh ? S'(CANVAS_MAX) : pot_up(grow_y));

  // Cell corners, saturated to the coordinate range
  logic [W-1:0] right_sum, bottom_sum;
  logic         ovf_l, ovf_t, ovf_r, ovf_b;

  assign right_sum  = cx1 + W'(rect_width_i);
  assign bottom_sum = cy1 + W'(rect_height_i);
  assign ovf_l      = cx1 > COORD_MAX;
  assign ovf_t      = cy1 > COORD_MAX;
  assign ovf_r      = right_sum > COORD_MAX;
  assign ovf_b      = bottom_sum > COORD_MAX;

  // Cursor advance and shelf height
  logic         ovf_cx, sh_upd, ovf_sh, ovf_place;
  logic [S-1:0] cx_place, sh_place;

  assign ovf_cx    = end_x > CANVAS_MAX;
  assign cx_place  = ovf_cx ? S'(CANVAS_MAX) : S'(end_x);
  assign sh_upd    = req_y > sh1;
  assign ovf_sh    = sh_upd && (req_y > CANVAS_MAX);
  assign sh_place  = !sh_upd ? S'(sh1) : (ovf_sh ? S'(CANVAS_MAX) : S'(req_y));
  assign ovf_place = ovf_wrap | ovf_gw | ovf_gh | ovf_l | ovf_t | ovf_r | ovf_b
                   | ovf_cx | ovf_sh;

  // Next state and corners per request kind
  always_comb begin
    cx_d          = cx_q;
    cy_d          = cy_q;
    sh_d          = sh_q;
    cw_d          = cw_q;
    ch_d          = ch_q;
    pw_d          = pw_q;
    ph_d          = ph_q;
    cell_left_o   = '0;
    cell_top_o    = '0;
    cell_right_o  = '0;
    cell_bottom_o = '0;
    overflow_o    = 1'b0;
    unique case (mode_e'(mode_i))
      MODE_PLACE: begin
        cx_d = cx_place;
        cy_d = S'(cy1);
        sh_d = sh_place;
        if (grow_w || grow_h) begin
          pw_d = new_w;
          ph_d = new_h;
        end
        cell_left_o   = ovf_l ? COORD_BITS'(COORD_MAX) : COORD_BITS'(cx1);
        cell_top_o    = ovf_t ? COORD_BITS'(COORD_MAX) : COORD_BITS'(cy1);
        cell_right_o  = ovf_r ? COORD_BITS'(COORD_MAX) : COORD_BITS'(right_sum);
        cell_bottom_o = ovf_b ? COORD_BITS'(COORD_MAX) : COORD_BITS'(bottom_sum);
        overflow_o    = ovf_place;
      end
      MODE_COMMIT: begin
        if (pend) begin
          cw_d = pw_q;
          ch_d = ph_q;
          pw_d = '0;
          ph_d = '0;
        end
      end
      MODE_RESTART: begin
        cw_d = clamp_size(init_width_i);
        ch_d = clamp_size(init_height_i);
        pw_d = '0;
        ph_d = '0;
        cx_d = S'(pad_x_i);
        cy_d = S'(pad_y_i);
        sh_d = '0;
      end
      default: begin
        // unused request kind: no change
      end
    endcase
  end

  // Effective canvas after the request
  assign canvas_width_o  = (pw_d != '0) ? pw_d : cw_d;
  assign canvas_height_o = (pw_d != '0) ? ph_d : ch_d;

  // State registers, advanced once per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      sh_q <= '0;
      cw_q <= S'(INIT_SIZE_RESET);
      ch_q <= S'(INIT_SIZE_RESET);
      pw_q <= '0;
      ph_q <= '0;
    end else if (en_i) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      sh_q <= sh_d;
      cw_q <= cw_d;
      ch_q <= ch_d;
      pw_q <= pw_d;
      ph_q <= ph_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/shelf_rect_packer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shelf_rect_packer
// Shelf packer placing rectangles in a growing atlas canvas. Each request
// places a rectangle, commits pending growth or restarts the atlas.
//
//   channel   direction  payload
//   s_axis    in         tuser: mode; tdata: rect_width, rect_height
//   m_axis    out        tdata: cell corners, canvas size, overflow
//   cfg       in         pad_x, pad_y, initial_width, initial_height
//
// One item per cycle sustained while the sink does not stall; the result passes
// through the input register, then the packing logic into the result register.
// The state update is one pass through srp_core, so items follow back to back.
// A stalled result holds in the output register while the input register
// still takes one more item. Reset clears the state to a 256 x 256 canvas,
// cursor at the origin and nothing pending; no clearing pass is needed.
// ----------------------------------------------------------------------------
module shelf_rect_packer
  import srp_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Requests
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // rect_width, rect_height
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // mode
  input  logic [MODE_W-1:0]     s_axis_tuser_i,
  // Results
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // cell_left, cell_top, cell_right, cell_bottom, canvas_width,
  // canvas_height, overflow
  output logic [((6*COORD_BITS+10)/8)*8-1:0] m_axis_tdata_o,
  // Configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned OUT_W     = ((6*COORD_BITS+10)/8)*8;
  localparam int unsigned RES_W     = 6*COORD_BITS + 3;

  // Configuration registers
  logic [PAD_W-1:0]      pad_x_q, pad_y_q;
  logic [SIZE_REG_W-1:0] init_w_q, init_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_x_q  <= '0;
      pad_y_q  <= '0;
      init_w_q <= SIZE_REG_W'(INIT_SIZE_RESET);
      init_h_q <= SIZE_REG_W'(INIT_SIZE_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PAD_X:  pad_x_q  <= cfg_wdata_i[PAD_W-1:0];
        REG_PAD_Y:  pad_y_q  <= cfg_wdata_i[PAD_W-1:0];
        REG_INIT_W: init_w_q <= cfg_wdata_i;
        REG_INIT_H: init_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on when the result register is free
  logic in_valid_q, out_valid_q, advance, in_take;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input register
  logic [MODE_W-1:0]     mode_q;
  logic [COORD_BITS-1:0] rect_w_q, rect_h_q;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q   <= s_axis_tuser_i;
      rect_w_q <= s_axis_tdata_i[COORD_BITS-1:0];
      rect_h_q <= s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS];
    end
  end

  // Packing logic and state
  logic [COORD_BITS-1:0] left, top, right, bottom;
  logic [COORD_BITS:0]   canvas_w, canvas_h;
  logic                  ovf;

  srp_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .mode_i          (mode_q),
    .rect_width_i    (rect_w_q),
    .rect_height_i   (rect_h_q),
    .pad_x_i         (pad_x_q),
    .pad_y_i         (pad_y_q),
    .init_width_i    (init_w_q),
    .init_height_i   (init_h_q),
    .cell_left_o     (left),
    .cell_top_o      (top),
    .cell_right_o    (right),
    .cell_bottom_o   (bottom),
    .canvas_width_o  (canvas_w),
    .canvas_height_o (canvas_h),
    .overflow_o      (ovf)
  );

  // Result register
  logic [RES_W-1:0] res_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= {ovf, canvas_h, canvas_w, bottom, right, top, left};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'(res_q);

endmodule
`default_nettype wire

/* rtl/srp_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srp_checker
// Port-level checks of the shelf rectangle packer's result stream, bound to
// the top level.
// ----------------------------------------------------------------------------
module srp_checker #(
  parameter int unsigned COORD_BITS = 16
) (
  input wire logic                                  clk_i,
  input wire logic                                  rst_ni,
  input wire logic                                  m_axis_tvalid_o,
  input wire logic                                  m_axis_tready_i,
  input wire logic [((6*COORD_BITS+10)/8)*8-1:0]    m_axis_tdata_o
);

  localparam int unsigned CB = COORD_BITS;

  logic [CB-1:0] left, top, right, bottom;
  logic [CB:0]   canvas_w, canvas_h;

  assign left     = m_axis_tdata_o[CB-1:0];
  assign top      = m_axis_tdata_o[2*CB-1:CB];
  assign right    = m_axis_tdata_o[3*CB-1:2*CB];
  assign bottom   = m_axis_tdata_o[4*CB-1:3*CB];
  assign canvas_w = m_axis_tdata_o[5*CB:4*CB];
  assign canvas_h = m_axis_tdata_o[6*CB+1:5*CB+1];

  // No result on the edge after one seen in reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // A stalled result keeps its item
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // Cell corners never invert
  a_corner_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (right >= left) && (bottom >= top))
    else $error("cell corners inverted");

  // Canvas size stays within 1 .. 2^COORD_BITS
  a_canvas_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (canvas_w != '0) && (canvas_h != '0)
                        && (canvas_w <= ((CB+1)'(1) << CB))
                        && (canvas_h <= ((CB+1)'(1) << CB)))
    else $error("canvas size out of range");

endmodule

bind shelf_rect_packer srp_checker #(
  .COORD_BITS (COORD_BITS)
) u_srp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire

/* verif/srp_cell_checker.sv */
// ----------------------------------------------------------------------------
// srp_cell_checker
// Watches the request, result and register-write ports of the shelf packer,
// keeps its own copy of cursor, shelf and canvas state, works out the cell
// and canvas size each request should give, and compares every result item
// in order. Reports the first ten mismatches; later ones are only counted.
// ----------------------------------------------------------------------------
module srp_cell_checker
  import srp_pkg::*;
#(
  parameter int unsigned CB = COORD_BITS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request channel
  input  logic                              req_valid_i,
  input  logic                              req_ready_i,
  // rect_width, rect_height
  input  logic [((2*CB+7)/8)*8-1:0]         req_data_i,
  // mode
  input  logic [MODE_W-1:0]                 req_mode_i,
  // Result channel
  input  logic                              res_valid_i,
  input  logic                              res_ready_i,
  // cell_left, cell_top, cell_right, cell_bottom, canvas_width,
  // canvas_height, overflow
  input  logic [((6*CB+10)/8)*8-1:0]        res_data_i,
  // Register writes
  input  logic                              cfg_we_i,
  input  logic [CFG_IDX_W-1:0]              cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]             cfg_wdata_i,
  // Tallies for the testbench top
  output int unsigned                       fail_count_o,
  output int unsigned                       outstanding_o,
  output int unsigned                       checked_o,
  output int unsigned                       overflow_seen_o
);

  typedef logic [CB-1:0] coord_t;
  typedef logic [CB:0]   size_t;
  typedef logic [CB+3:0] wide_t;

  localparam wide_t CANVAS_MAX = wide_t'(1) << CB;
  localparam wide_t COORD_MAX  = CANVAS_MAX - wide_t'(1);

  typedef struct packed {
    coord_t left_x;
    coord_t top_y;
    coord_t right_x;
    coord_t bottom_y;
    size_t  canvas_w;
    size_t  canvas_h;
    logic   ovf;
  } cell_t;

  // Packer state and register copies
  size_t                 cur_x, cur_y, shelf_h;
  size_t                 comm_w, comm_h, pend_w, pend_h;
  logic [PAD_W-1:0]      pad_x, pad_y;
  logic [SIZE_REG_W-1:0] init_w, init_h;
  logic                  clip_hit;

  cell_t       cells_due[$];
  cell_t       got, want;
  logic        bad;
  int unsigned fail_count    = 0;
  int unsigned outstanding   = 0;
  int unsigned checked       = 0;
  int unsigned overflow_seen = 0;

  assign fail_count_o    = fail_count;
  assign outstanding_o   = outstanding;
  assign checked_o       = checked;
  assign overflow_seen_o = overflow_seen;

  // Saturate at a limit, noting that it happened
  function automatic wide_t clip(input wide_t v, input wide_t lim);
    if (v > lim) begin
      clip_hit = 1'b1;
      return lim;
    end
    return v;
  endfunction

  // Smallest power of two not below v, capped at the canvas limit
  function automatic wide_t pow2_ceil(input wide_t v);
    wide_t p;
    p = wide_t'(1);
    if (v > CANVAS_MAX) begin
      clip_hit = 1'b1;
      return CANVAS_MAX;
    end
    while (p < v) p = p << 1;
    return p;
  endfunction

  // Initial size as loaded on restart: zero reads as one, big values cap
  function automatic size_t fit_size(input logic [SIZE_REG_W-1:0] v);
    if (v == '0) return size_t'(1);
    if (wide_t'(v) > CANVAS_MAX) return size_t'(CANVAS_MAX);
    return size_t'(v);
  endfunction

  function automatic string show(input cell_t c);
    return $sformatf("L=%0d T=%0d R=%0d B=%0d W=%0d H=%0d ovf=%0b",
                     c.left_x, c.top_y, c.right_x, c.bottom_y,
                     c.canvas_w, c.canvas_h, c.ovf);
  endfunction

  // One request through the packer: updates state, returns the cell
  function automatic cell_t pack_step(input logic [MODE_W-1:0] mode,
                                      input coord_t w, input coord_t h);
    wide_t req_x, req_y, lim_w, lim_h, new_w, new_h;
    logic  grow;
    cell_t res;
    res      = '0;
    clip_hit = 1'b0;
    case (mode)
      MODE_PLACE: begin
        req_x = wide_t'(w) + wide_t'(pad_x);
        req_y = wide_t'(h) + wide_t'(pad_y);
        lim_w = (pend_w != '0) ? wide_t'(pend_w) : wide_t'(comm_w);
        lim_h = (pend_w != '0) ? wide_t'(pend_h) : wide_t'(comm_h);
        // new shelf when the padded width leaves the committed width
        if (wide_t'(cur_x) + req_x > wide_t'(comm_w)) begin
          cur_y   = size_t'(clip(wide_t'(cur_y) + wide_t'(shelf_h) + wide_t'(pad_y),
                                 CANVAS_MAX));
          cur_x   = size_t'(pad_x);
          shelf_h = '0;
        end
        // growth of the effective canvas, width from the cursor
        grow  = 1'b0;
        new_w = lim_w;
        new_h = lim_h;
        if (wide_t'(cur_x) + req_x > lim_w) begin
          grow  = 1'b1;
          new_w = pow2_ceil(wide_t'(cur_x) + req_x);
        end
        if (wide_t'(cur_y) + req_y > lim_h) begin
          grow  = 1'b1;
          new_h = pow2_ceil(lim_h + req_y);
        end
        if (grow) begin
          pend_w = size_t'(new_w);
          pend_h = size_t'(new_h);
        end
        res.left_x   = coord_t'(clip(wide_t'(cur_x), COORD_MAX));
        res.top_y    = coord_t'(clip(wide_t'(cur_y), COORD_MAX));
        res.right_x  = coord_t'(clip(wide_t'(cur_x) + wide_t'(w), COORD_MAX));
        res.bottom_y = coord_t'(clip(wide_t'(cur_y) + wide_t'(h), COORD_MAX));
        cur_x = size_t'(clip(wide_t'(cur_x) + req_x, CANVAS_MAX));
        if (req_y > wide_t'(shelf_h)) shelf_h = size_t'(clip(req_y, CANVAS_MAX));
      end
      MODE_COMMIT: begin
        if (pend_w != '0) begin
          comm_w = pend_w;
          comm_h = pend_h;
          pend_w = '0;
          pend_h = '0;
        end
      end
      MODE_RESTART: begin
        comm_w  = fit_size(init_w);
        comm_h  = fit_size(init_h);
        pend_w  = '0;
        pend_h  = '0;
        cur_x   = size_t'(pad_x);
        cur_y   = size_t'(pad_y);
        shelf_h = '0;
      end
      default: ;
    endcase
    res.canvas_w = (pend_w != '0) ? pend_w : comm_w;
    res.canvas_h = (pend_w != '0) ? pend_h : comm_h;
    res.ovf      = clip_hit;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x   = '0;
      cur_y   = '0;
      shelf_h = '0;
      comm_w  = size_t'(INIT_SIZE_RESET);
      comm_h  = size_t'(INIT_SIZE_RESET);
      pend_w  = '0;
      pend_h  = '0;
      pad_x   = '0;
      pad_y   = '0;
      init_w  = SIZE_REG_W'(INIT_SIZE_RESET);
      init_h  = SIZE_REG_W'(INIT_SIZE_RESET);
      cells_due.delete();
      outstanding = 0;
    end else begin
      // user keeps register writes to an idle packer; not checked
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_PAD_X:  pad_x  = cfg_wdata_i[PAD_W-1:0];
          REG_PAD_Y:  pad_y  = cfg_wdata_i[PAD_W-1:0];
          REG_INIT_W: init_w = cfg_wdata_i[SIZE_REG_W-1:0];
          REG_INIT_H: init_h = cfg_wdata_i[SIZE_REG_W-1:0];
          default: ;
        endcase
      end
      // result item leaves the block
      if (res_valid_i && res_ready_i) begin
        got.left_x   = res_data_i[CB-1:0];
        got.top_y    = res_data_i[2*CB-1:CB];
        got.right_x  = res_data_i[3*CB-1:2*CB];
        got.bottom_y = res_data_i[4*CB-1:3*CB];
        got.canvas_w = res_data_i[5*CB:4*CB];
        got.canvas_h = res_data_i[6*CB+1:5*CB+1];
        got.ovf      = res_data_i[6*CB+2];
        if (got.ovf) overflow_seen++;
        if (cells_due.size() == 0) begin
          if (fail_count < 10)
            $display("[%0t] result with nothing expected: %s", $realtime, show(got));
          fail_count++;
        end else begin
          want = cells_due.pop_front();
          checked++;
          bad = (got.left_x !== want.left_x) || (got.top_y !== want.top_y) ||
                (got.right_x !== want.right_x) || (got.bottom_y !== want.bottom_y) ||
                (got.canvas_w !== want.canvas_w) || (got.canvas_h !== want.canvas_h) ||
                (got.ovf !== want.ovf);
          if (bad) begin
            if (fail_count < 10) begin
              $display("[%0t] result %0d mismatch", $realtime, checked);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
            fail_count++;
          end
        end
      end
      // request item enters the block
      if (req_valid_i && req_ready_i)
        cells_due.insert(cells_due.size(), pack_step(req_mode_i, req_data_i[CB-1:0],
                                                     req_data_i[2*CB-1:CB]));
      outstanding = cells_due.size();
    end
  end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench top of the shelf rectangle packer. Drives a directed set of
// corner requests, then four random phases with different register settings
// and source idling / sink stalling mixes. Prediction and comparison live in
// srp_cell_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import srp_pkg::*;

  localparam int unsigned CB     = COORD_BITS_DEFAULT;
  localparam int unsigned DIN_W  = ((2*CB+7)/8)*8;
  localparam int unsigned DOUT_W = ((6*CB+10)/8)*8;

  // Request code the block leaves unused
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [DIN_W-1:0]      s_axis_tdata_i  = '0;
  logic [MODE_W-1:0]     s_axis_tuser_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [DOUT_W-1:0]     m_axis_tdata_o;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i     = '0;

  int unsigned fail_total, outstanding, results_checked, overflow_seen;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned sent_by_mode [4] = '{default: 0};

  always #5 clk_i = ~clk_i;

  shelf_rect_packer #(
    .COORD_BITS (CB)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  srp_cell_checker #(
    .CB (CB)
  ) u_cells (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (s_axis_tvalid_i),
    .req_ready_i     (s_axis_tready_o),
    .req_data_i      (s_axis_tdata_i),
    .req_mode_i      (s_axis_tuser_i),
    .res_valid_i     (m_axis_tvalid_o),
    .res_ready_i     (m_axis_tready_i),
    .res_data_i      (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .fail_count_o    (fail_total),
    .outstanding_o   (outstanding),
    .checked_o       (results_checked),
    .overflow_seen_o (overflow_seen)
  );

  // Sink back-pressure
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Hand one request to the block; entered and left at a falling edge
  task automatic send_req(input logic [MODE_W-1:0] mode,
                          input logic [CB-1:0] w, input logic [CB-1:0] h);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {h, w};
    s_axis_tuser_i  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sent_by_mode[mode]++;
    @(negedge clk_i);
  endtask

  // Write all four registers once the packer has drained
  task automatic set_config(input logic [PAD_W-1:0] px, input logic [PAD_W-1:0] py,
                            input logic [SIZE_REG_W-1:0] iw,
                            input logic [SIZE_REG_W-1:0] ih);
    s_axis_tvalid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_PAD_X;
    cfg_wdata_i <= CFG_DATA_W'(px);
    @(negedge clk_i);
    cfg_idx_i   <= REG_PAD_Y;
    cfg_wdata_i <= CFG_DATA_W'(py);
    @(negedge clk_i);
    cfg_idx_i   <= REG_INIT_W;
    cfg_wdata_i <= CFG_DATA_W'(iw);
    @(negedge clk_i);
    cfg_idx_i   <= REG_INIT_H;
    cfg_wdata_i <= CFG_DATA_W'(ih);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly small rectangles so shelves fill; a few mid-size and full-range
  function automatic logic [CB-1:0] rand_side();
    int unsigned s;
    s = $urandom_range(99);
    if (s < 84) return CB'($urandom_range(0, 40));
    if (s < 95) return CB'($urandom_range(0, 2047));
    return CB'($urandom);
  endfunction

  task automatic random_items(input int unsigned n);
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 78)      send_req(MODE_PLACE, rand_side(), rand_side());
      else if (r < 91) send_req(MODE_COMMIT, rand_side(), rand_side());
      else if (r < 96) send_req(MODE_RESTART, rand_side(), rand_side());
      else             send_req(MODE_UNUSED, rand_side(), rand_side());
    end
  endtask

  task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct,
                           input logic [PAD_W-1:0] px, input logic [PAD_W-1:0] py,
                           input logic [SIZE_REG_W-1:0] iw,
                           input logic [SIZE_REG_W-1:0] ih,
                           input int unsigned n);
    set_config(px, py, iw, ih);
    idle_pct  = src_pct;
    stall_pct = snk_pct;
    send_req(MODE_RESTART, '0, '0);
    random_items(n);
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset registers, 256 x 256 canvas
    send_req(MODE_PLACE, 16'd0, 16'd0);
    send_req(MODE_PLACE, 16'd16, 16'd16);
    send_req(MODE_PLACE, 16'd240, 16'd8);        // exactly fills the width
    send_req(MODE_PLACE, 16'd1, 16'd1);          // wraps to a new shelf
    send_req(MODE_PLACE, 16'd300, 16'd20);       // wider than canvas: grows
    send_req(MODE_UNUSED, 16'hFFFF, 16'hFFFF);
    send_req(MODE_COMMIT, 16'd0, 16'd0);
    send_req(MODE_COMMIT, 16'd0, 16'd0);         // nothing pending
    send_req(MODE_PLACE, 16'hFFFF, 16'hFFFF);    // size saturates
    send_req(MODE_PLACE, 16'hFFFF, 16'hFFFF);    // corners and cursor saturate
    send_req(MODE_PLACE, 16'h5555, 16'hAAAA);
    send_req(MODE_COMMIT, 16'd0, 16'd0);
    send_req(MODE_RESTART, 16'd0, 16'd0);

    // Directed: widest padding, initial sizes out of range
    set_config(8'hFF, 8'hFF, '0, '1);
    send_req(MODE_RESTART, 16'd0, 16'd0);
    send_req(MODE_PLACE, 16'd0, 16'd0);
    send_req(MODE_PLACE, 16'hAAAA, 16'h5555);
    send_req(MODE_PLACE, 16'hFFFF, 16'd0);
    send_req(MODE_COMMIT, 16'd0, 16'd0);
    send_req(MODE_UNUSED, 16'd0, 16'd0);
    send_req(MODE_PLACE, 16'd1, 16'd1);

    // Random phases: none, source idle, sink stall, both
    run_phase(0, 0, 8'd2, 8'd1, 17'd64, 17'd32, 333);
    run_phase(83, 0, 8'd255, 8'd255, 17'd65536, 17'd65536, 333);
    run_phase(0, 83, 8'd0, 8'd0, 17'd1, 17'd1, 333);
    run_phase(24, 24, PAD_W'($urandom_range(0, 255)), PAD_W'($urandom_range(0, 255)),
              SIZE_REG_W'($urandom_range(1, 4096)), SIZE_REG_W'($urandom_range(1, 4096)),
              333);

    // Drain
    s_axis_tvalid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);

    $display("Ran %0d requests: %0d place, %0d commit, %0d restart, %0d unused code",
             sent_by_mode[0] + sent_by_mode[1] + sent_by_mode[2] + sent_by_mode[3],
             sent_by_mode[MODE_PLACE], sent_by_mode[MODE_COMMIT],
             sent_by_mode[MODE_RESTART], sent_by_mode[MODE_UNUSED]);
    $display("%0d results checked, %0d flagged overflow, 6 register settings, %0d failures",
             results_checked, overflow_seen, fail_total);
    if (fail_total == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", outstanding);
    $display("== FAIL ==");
    $finish;
  end

endmodule
